FILE: src/rbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_pkg
// Types and constants shared by the RGB box blur stream core.
// ----------------------------------------------------------------------------
package rbb_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_RADIUS = 7;

   localparam int CFG_W_BITS = 11;
   localparam int CFG_H_BITS = 16;
   localparam int CFG_R_BITS = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CHAN_W     = 8;
   localparam int SUM_W      = 16;   // 15x15 window of 8-bit values
   localparam int BOX_W      = 8;    // at most 225

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_Y     = 2'd3;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_end;
   } rsp_type;

endpackage
`default_nettype wire

FILE: src/rgb_box_blur_stream_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_box_blur_stream_core
// Zero-padded RGB box blur over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and go into a ring line store (one
// synchronous RAM, MAX_WIDTH*(2*MAX_RADIUS+1)+2*MAX_RADIUS+1 entries). When
// enough of the frame is in, an item produces the blurred pixel that lags
// it by radius_y*width+radius_x positions; flush items drain the rest after
// the frame, and the last result carries frame_end. Items are handled one at
// a time. An item that produces no result passes through the idle, setup,
// position and operation states. One that produces a result then runs a
// serial divide of P = 16+clog2(MAX_WIDTH+1) (27 by default) steps that
// splits the output position into row and column, walks the window over the
// line store (address, RAM read, accumulate per tap), runs the 16-step
// serial divide by the box size plus its closing step, and issues the
// result, waiting while a previous result is stalled. Outside-frame taps
// count as zero, so edges darken. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module rgb_box_blur_stream_core
   import rbb_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rsp_type              rsp_data,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * (2 * MAX_RADIUS + 1) + 2 * MAX_RADIUS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = $clog2(DEPTH + 1);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int POS_W = CFG_H_BITS + WW;
   localparam int SW    = POS_W + 2;
   localparam int YW    = CFG_H_BITS + 2;
   localparam int XW    = WW + 2;
   localparam int CNW   = $clog2(POS_W + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_POS, S_OP, S_DIV, S_WADDR, S_WREAD, S_WACC, S_QUOT, S_OUT
   } state_type;

   // configuration
   logic [CFG_W_BITS-1:0] cfg_w_ff;
   logic [CFG_H_BITS-1:0] cfg_h_ff;
   logic [CFG_R_BITS-1:0] cfg_rx_ff, cfg_ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff  <= CFG_W_BITS'(1024);
         cfg_h_ff  <= CFG_H_BITS'(1024);
         cfg_rx_ff <= CFG_R_BITS'(1);
         cfg_ry_ff <= CFG_R_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_w_ff  <= csr_wdata[CFG_W_BITS-1:0];
            CSR_FRAME_HEIGHT: cfg_h_ff  <= csr_wdata[CFG_H_BITS-1:0];
            CSR_RADIUS_X:     cfg_rx_ff <= csr_wdata[CFG_R_BITS-1:0];
            CSR_RADIUS_Y:     cfg_ry_ff <= csr_wdata[CFG_R_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective frame geometry (zero sizes become 1, oversize saturates)
   logic [WW-1:0]         w_eff;
   logic [CFG_H_BITS-1:0] h_eff;
   logic [CFG_R_BITS-1:0] rx_eff, ry_eff;

   always_comb begin
      if (cfg_w_ff == '0)                        w_eff = WW'(1);
      else if (32'(cfg_w_ff) > 32'(MAX_WIDTH))   w_eff = WW'(MAX_WIDTH);
      else                                       w_eff = WW'(cfg_w_ff);
      h_eff  = (cfg_h_ff == '0) ? CFG_H_BITS'(1) : cfg_h_ff;
      rx_eff = (32'(cfg_rx_ff) > 32'(MAX_RADIUS)) ? CFG_R_BITS'(MAX_RADIUS) : cfg_rx_ff;
      ry_eff = (32'(cfg_ry_ff) > 32'(MAX_RADIUS)) ? CFG_R_BITS'(MAX_RADIUS) : cfg_ry_ff;
   end

   // line store
   logic [3*CHAN_W-1:0] mem [DEPTH];
   logic [3*CHAN_W-1:0] rd_ff;
   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       rd_addr;

   state_type       state_ff;
   req_type         item_ff;
   rsp_type         rsp_ff;
   logic            rsp_valid_ff;
   logic [AW-1:0]   wp_ff;
   logic [WW-1:0]   col_ff;
   logic [CFG_H_BITS-1:0] row_ff;
   logic [POS_W-1:0] out_ff, in_pos_ff, total_ff, base_ff, lag_ff;
   logic [BOX_W-1:0] box_ff;
   logic [CNW-1:0]   cnt_ff;
   logic [POS_W-1:0] dnum_ff;
   logic [WW-1:0]    drem_ff;
   logic signed [SW-1:0] s_ff;
   logic signed [YW-1:0] ny_ff;
   logic signed [XW-1:0] nx_ff;
   logic [3:0]       cx_ff, cy_ff;
   logic             ok_ff, last_ff;
   logic [BW-1:0]    back1_ff;
   logic [SUM_W-1:0] sr_ff, sg_ff, sb_ff;
   logic [SUM_W-1:0] qr_ff, qg_ff, qb_ff;
   logic [BOX_W-1:0] rr_ff, rg_ff, rb_ff;

   // serial divide of output position by width
   logic [WW:0] dtrial, ddiff;
   assign dtrial = {drem_ff, dnum_ff[POS_W-1]};
   assign ddiff  = dtrial - {1'b0, w_eff};

   // serial divide of channel sums by box size
   logic [BOX_W:0] tr, tg, tb, dr, dg, db;
   assign tr = {rr_ff, qr_ff[SUM_W-1]};
   assign tg = {rg_ff, qg_ff[SUM_W-1]};
   assign tb = {rb_ff, qb_ff[SUM_W-1]};
   assign dr = tr - {1'b0, box_ff};
   assign dg = tg - {1'b0, box_ff};
   assign db = tb - {1'b0, box_ff};

   // tap address checks
   logic signed [SW-1:0] tap_back1;
   logic                 tap_ok;
   assign tap_back1 = $signed({2'b00, in_pos_ff}) - s_ff;
   assign tap_ok = (ny_ff >= 0) && (ny_ff < $signed({2'b00, h_eff}))
                && (nx_ff >= 0) && (nx_ff < $signed({2'b00, w_eff}))
                && (tap_back1 > 0) && (tap_back1 <= $signed(SW'(DEPTH)));

   logic [BW-1:0] wp_ext;
   assign wp_ext  = BW'(wp_ff);
   assign rd_addr = (wp_ext >= back1_ff) ? AW'(wp_ext - back1_ff)
                                         : AW'(BW'(DEPTH) + wp_ext - back1_ff);

   logic [3:0] rx2, ry2;
   assign rx2 = {rx_eff, 1'b0};
   assign ry2 = {ry_eff, 1'b0};

   assign mem_we = (state_ff == S_OP) && (item_ff.operation == OP_PIXEL)
                && (in_pos_ff < total_ff);
   assign mem_re = (state_ff == S_WREAD) && ok_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wp_ff] <= {item_ff.red, item_ff.green, item_ff.blue};
      if (mem_re) rd_ff <= mem[rd_addr];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [POS_W-1:0] in_next;
   assign in_next = in_pos_ff + POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         out_ff       <= '0;
      end else begin
         // S_OUT loads the next result itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               total_ff <= POS_W'(POS_W'(w_eff) * POS_W'(h_eff));
               base_ff  <= POS_W'(POS_W'(row_ff) * POS_W'(w_eff));
               lag_ff   <= POS_W'(POS_W'(ry_eff) * POS_W'(w_eff) + POS_W'(rx_eff));
               box_ff   <= (BOX_W'(rx2) + BOX_W'(1)) * (BOX_W'(ry2) + BOX_W'(1));
               state_ff <= S_POS;
            end
            S_POS: begin
               if (out_ff >= total_ff) begin
                  col_ff    <= '0;
                  row_ff    <= '0;
                  out_ff    <= '0;
                  in_pos_ff <= '0;
               end else begin
                  in_pos_ff <= base_ff + POS_W'(col_ff);
               end
               state_ff <= S_OP;
            end
            S_OP: begin
               dnum_ff  <= out_ff;
               drem_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= S_IDLE;
               if (item_ff.operation == OP_PIXEL) begin
                  if (in_pos_ff < total_ff) begin
                     wp_ff     <= (32'(wp_ff) + 1 >= DEPTH) ? '0 : wp_ff + AW'(1);
                     in_pos_ff <= in_next;
                     if (col_ff + WW'(1) >= w_eff) begin
                        col_ff <= '0;
                        row_ff <= row_ff + CFG_H_BITS'(1);
                     end else begin
                        col_ff <= col_ff + WW'(1);
                     end
                     if (out_ff + lag_ff < in_next) state_ff <= S_DIV;
                  end
               end else if (in_pos_ff >= total_ff && out_ff < total_ff) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (cnt_ff == CNW'(POS_W)) begin
                  // dnum holds row, drem holds column of the output position
                  ny_ff    <= $signed({2'b00, dnum_ff[CFG_H_BITS-1:0]})
                            - $signed(YW'(ry_eff));
                  nx_ff    <= $signed({2'b00, drem_ff}) - $signed(XW'(rx_eff));
                  s_ff     <= $signed({2'b00, out_ff}) - $signed({2'b00, lag_ff});
                  cx_ff    <= '0;
                  cy_ff    <= '0;
                  sr_ff    <= '0;
                  sg_ff    <= '0;
                  sb_ff    <= '0;
                  state_ff <= S_WADDR;
               end else begin
                  if (!ddiff[WW]) drem_ff <= ddiff[WW-1:0];
                  else            drem_ff <= dtrial[WW-1:0];
                  dnum_ff <= {dnum_ff[POS_W-2:0], ~ddiff[WW]};
                  cnt_ff  <= cnt_ff + CNW'(1);
               end
            end
            S_WADDR: begin
               ok_ff    <= tap_ok;
               back1_ff <= BW'(tap_back1);
               state_ff <= S_WREAD;
            end
            S_WREAD: begin
               last_ff <= (cx_ff == rx2) && (cy_ff == ry2);
               if (cx_ff == rx2) begin
                  cx_ff <= '0;
                  cy_ff <= cy_ff + 4'd1;
                  nx_ff <= nx_ff - $signed(XW'(rx2));
                  ny_ff <= ny_ff + YW'(1);
                  s_ff  <= s_ff + $signed(SW'(w_eff)) - $signed(SW'(rx2));
               end else begin
                  cx_ff <= cx_ff + 4'd1;
                  nx_ff <= nx_ff + XW'(1);
                  s_ff  <= s_ff + SW'(1);
               end
               state_ff <= S_WACC;
            end
            S_WACC: begin
               if (ok_ff) begin
                  sr_ff <= sr_ff + SUM_W'(rd_ff[3*CHAN_W-1:2*CHAN_W]);
                  sg_ff <= sg_ff + SUM_W'(rd_ff[2*CHAN_W-1:CHAN_W]);
                  sb_ff <= sb_ff + SUM_W'(rd_ff[CHAN_W-1:0]);
               end
               if (last_ff) begin
                  qr_ff    <= ok_ff ? sr_ff + SUM_W'(rd_ff[3*CHAN_W-1:2*CHAN_W]) : sr_ff;
                  qg_ff    <= ok_ff ? sg_ff + SUM_W'(rd_ff[2*CHAN_W-1:CHAN_W]) : sg_ff;
                  qb_ff    <= ok_ff ? sb_ff + SUM_W'(rd_ff[CHAN_W-1:0]) : sb_ff;
                  rr_ff    <= '0;
                  rg_ff    <= '0;
                  rb_ff    <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_QUOT;
               end else begin
                  state_ff <= S_WADDR;
               end
            end
            S_QUOT: begin
               if (cnt_ff == CNW'(SUM_W)) begin
                  state_ff <= S_OUT;
               end else begin
                  rr_ff  <= dr[BOX_W] ? tr[BOX_W-1:0] : dr[BOX_W-1:0];
                  rg_ff  <= dg[BOX_W] ? tg[BOX_W-1:0] : dg[BOX_W-1:0];
                  rb_ff  <= db[BOX_W] ? tb[BOX_W-1:0] : db[BOX_W-1:0];
                  qr_ff  <= {qr_ff[SUM_W-2:0], ~dr[BOX_W]};
                  qg_ff  <= {qg_ff[SUM_W-2:0], ~dg[BOX_W]};
                  qb_ff  <= {qb_ff[SUM_W-2:0], ~db[BOX_W]};
                  cnt_ff <= cnt_ff + CNW'(1);
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.red_out   <= qr_ff[CHAN_W-1:0];
                  rsp_ff.green_out <= qg_ff[CHAN_W-1:0];
                  rsp_ff.blue_out  <= qb_ff[CHAN_W-1:0];
                  rsp_ff.frame_end <= (out_ff + POS_W'(1) == total_ff);
                  rsp_valid_ff     <= 1'b1;
                  if (out_ff + POS_W'(1) >= total_ff) begin
                     // frame done: next pixel starts a new frame
                     out_ff <= '0;
                     col_ff <= '0;
                     row_ff <= '0;
                  end else begin
                     out_ff <= out_ff + POS_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      32'(wp_ff) < DEPTH) else $error("write pointer out of range");
   a_op_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OP |-> out_ff < total_ff) else $error("output position past frame");
   a_tap_back: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WREAD && ok_ff) |-> (back1_ff != '0 && 32'(back1_ff) <= DEPTH))
      else $error("tap outside line store");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not issued");
`endif

endmodule
`default_nettype wire

FILE: bench/rgb_box_blur_stream_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_blur_stream_core_test
// Self-checking bench for the RGB box blur stream core.
// ----------------------------------------------------------------------------
// Frames of random RGB pixels go in through the request channel, flush items
// drain what is left, and every blurred pixel is checked against a local
// zero-padded box blur predictor that mirrors the ring store and position
// counters. Directed frames cover channel extremes, degenerate and saturated
// sizes, the largest window and a height change in the middle of a frame;
// random frames follow with random sizes, stray flushes and extra pixels.
// ----------------------------------------------------------------------------
module rgb_box_blur_stream_core_test;
   import rbb_pkg::*;

   localparam int MAX_W       = DEF_MAX_WIDTH;
   localparam int MAX_R       = DEF_MAX_RADIUS;
   localparam int RING_DEPTH  = MAX_W * (2 * MAX_R + 1) + 2 * MAX_R + 1;
   // longest result: row/column divide, 15x15 window walk, box divide
   localparam int RESULT_LAT  = 800;
   localparam int ITEM_SETTLE = 50;
   localparam int RANDOM_PIX  = 600;

   // pattern codes for pixel content
   localparam int PAT_RANDOM  = 0;
   localparam int PAT_EXTREME = 1;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rgb_box_blur_stream_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Handshakes are sampled mid-cycle, where everything is settled; the
   // following rising edge is the one that moves the item.
   logic    req_take = 1'b0;
   logic    rsp_take = 1'b0;
   rsp_type rsp_seen;

   always @(negedge clock) begin
      req_take = req_valid && req_ready;
      rsp_take = rsp_valid && rsp_ready;
      rsp_seen = rsp_data;
   end

   int errors     = 0;
   bit idling     = 1'b1;   // random gaps and stalls allowed
   int pixels_in  = 0;      // pixels that entered a frame

   task automatic report(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   // ------------------------------------------------------------------------
   // Blur predictor: same ring store and counters as the core
   // ------------------------------------------------------------------------
   logic [23:0] pix_ring [RING_DEPTH];
   int          ring_wr;
   longint      col_in, row_in, out_pos;
   logic [10:0] cfg_width;
   logic [15:0] cfg_height;
   logic [2:0]  cfg_rx, cfg_ry;
   rsp_type     blurred_q [$];

   function automatic longint width_eff();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic longint height_eff();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic longint radius_eff(input logic [2:0] r);
      return (r > MAX_R) ? MAX_R : r;
   endfunction

   // pixel at frame position s, with in_pos pixels of the frame taken
   function automatic logic [23:0] ring_pixel(input longint s, input longint in_pos);
      longint back, idx;
      if (s >= in_pos) return '0;
      back = in_pos - 1 - s;
      if (back >= RING_DEPTH) return '0;
      if (ring_wr >= back + 1) idx = ring_wr - back - 1;
      else idx = ring_wr + RING_DEPTH - back - 1;
      return pix_ring[idx];
   endfunction

   function automatic void blur_output(input longint w, input longint h,
                                       input longint in_pos);
      longint      rx, ry, box, px, py, ny, nx;
      longint      sr, sg, sb;
      logic [23:0] c;
      rsp_type     res;
      rx  = radius_eff(cfg_rx);
      ry  = radius_eff(cfg_ry);
      box = (2 * rx + 1) * (2 * ry + 1);
      px  = out_pos % w;
      py  = out_pos / w;
      sr  = 0;
      sg  = 0;
      sb  = 0;
      for (longint dy = -ry; dy <= ry; dy++) begin
         ny = py + dy;
         if (ny < 0 || ny >= h) continue;
         for (longint dx = -rx; dx <= rx; dx++) begin
            nx = px + dx;
            if (nx < 0 || nx >= w) continue;
            c = ring_pixel(ny * w + nx, in_pos);
            sr += c[23:16];
            sg += c[15:8];
            sb += c[7:0];
         end
      end
      res.red_out   = 8'(sr / box);
      res.green_out = 8'(sg / box);
      res.blue_out  = 8'(sb / box);
      res.frame_end = (out_pos + 1 == w * h);
      blurred_q.push_back(res);
      out_pos++;
      if (out_pos >= w * h) begin
         col_in  = 0;
         row_in  = 0;
         out_pos = 0;
      end
   endfunction

   function automatic void predict_item(input req_type it);
      longint w, h, total, lag, in_pos;
      w     = width_eff();
      h     = height_eff();
      total = w * h;
      lag   = radius_eff(cfg_ry) * w + radius_eff(cfg_rx);
      if (out_pos >= total) begin
         col_in  = 0;
         row_in  = 0;
         out_pos = 0;
      end
      in_pos = row_in * w + col_in;
      if (it.operation == OP_PIXEL) begin
         if (in_pos >= total) return;   // extra pixel while draining
         pixels_in++;
         pix_ring[ring_wr] = {it.red, it.green, it.blue};
         ring_wr = (ring_wr + 1 >= RING_DEPTH) ? 0 : ring_wr + 1;
         col_in++;
         if (col_in >= w) begin
            col_in = 0;
            row_in++;
         end
         in_pos++;
         if (out_pos + lag < in_pos) blur_output(w, h, in_pos);
      end else if (in_pos >= total && out_pos < total) begin
         blur_output(w, h, in_pos);
      end
   endfunction

   function automatic bit frame_open();
      return (col_in != 0) || (row_in != 0) || (out_pos != 0);
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stalls and the checker
   // ------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (rsp_take) begin
         if (blurred_q.size() == 0) begin
            report($sformatf("unexpected result %h", rsp_seen));
         end else begin
            want = blurred_q.pop_front();
            if (rsp_seen.red_out !== want.red_out)
               report($sformatf("red %0d, want %0d", rsp_seen.red_out, want.red_out));
            if (rsp_seen.green_out !== want.green_out)
               report($sformatf("green %0d, want %0d", rsp_seen.green_out,
                                want.green_out));
            if (rsp_seen.blue_out !== want.blue_out)
               report($sformatf("blue %0d, want %0d", rsp_seen.blue_out,
                                want.blue_out));
            if (rsp_seen.frame_end !== want.frame_end)
               report($sformatf("frame_end %0b, want %0b", rsp_seen.frame_end,
                                want.frame_end));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Called and returning right after a rising edge.
   task automatic send_item(input req_type it);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_take);
      predict_item(it);
   endtask

   task automatic send_pixel(input int pattern, input int n);
      req_type it;
      it.operation = OP_PIXEL;
      if (pattern == PAT_EXTREME) begin
         // walk through all-zero, all-one and mixed channel corners
         it.red   = n[0] ? 8'hff : 8'h00;
         it.green = n[1] ? 8'hff : 8'h00;
         it.blue  = n[2] ? 8'h00 : 8'hff;
      end else begin
         it.red   = 8'($urandom);
         it.green = 8'($urandom);
         it.blue  = 8'($urandom);
      end
      send_item(it);
   endtask

   task automatic send_flush();
      req_type it;
      it           = req_type'($urandom);
      it.operation = OP_FLUSH;   // channels are don't-care here
      send_item(it);
   endtask

   // all results in, and any no-result item finished
   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // one write, then the write strobe drops before the model is updated
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = val[10:0];
         CSR_FRAME_HEIGHT: cfg_height = val;
         CSR_RADIUS_X:     cfg_rx     = val[2:0];
         CSR_RADIUS_Y:     cfg_ry     = val[2:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int w, input int h, input int rx, input int ry);
      wait_idle(ITEM_SETTLE);
      csr_write(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      csr_write(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      csr_write(CSR_RADIUS_X, CSR_DATA_W'(rx));
      csr_write(CSR_RADIUS_Y, CSR_DATA_W'(ry));
   endtask

   // One whole frame; with noise, stray flushes land before the frame is
   // complete and extra pixels land during the drain (both ignored).
   task automatic run_frame(input int pattern, input bit noise);
      longint total;
      total = width_eff() * height_eff();
      for (longint i = 0; i < total; i++) begin
         if (noise && $urandom_range(0, 15) == 0) send_flush();
         send_pixel(pattern, int'(i));
      end
      while (frame_open()) begin
         if (noise && $urandom_range(0, 7) == 0) send_pixel(PAT_RANDOM, 0);
         send_flush();
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // 3x3 frame of channel corners; flush with nothing pending, stray items
   task automatic test_channel_extremes();
      set_geometry(3, 3, 1, 1);
      send_flush();                 // nothing pending
      run_frame(PAT_EXTREME, 1'b1);
      send_flush();                 // after frame end
   endtask

   // width and height zero clamp to one, no window
   task automatic test_degenerate_size();
      set_geometry(0, 0, 0, 0);
      send_pixel(PAT_EXTREME, 7);
      send_pixel(PAT_EXTREME, 0);   // starts the next frame
   endtask

   // largest window on a frame smaller than it
   task automatic test_max_window();
      set_geometry(4, 3, 7, 7);
      run_frame(PAT_EXTREME, 1'b0);
      set_geometry(5, 2, 7, 0);
      run_frame(PAT_RANDOM, 1'b0);
   endtask

   // over-wide row saturates at the store width
   task automatic test_wide_row();
      set_geometry(2047, 1, 0, 0);
      run_frame(PAT_RANDOM, 1'b0);
   endtask

   // tall frame cut short by a height write partway through
   task automatic test_height_change();
      set_geometry(1, 65535, 0, 2);
      for (int i = 0; i < 8; i++) send_pixel(PAT_RANDOM, i);
      wait_idle(ITEM_SETTLE);
      csr_write(CSR_FRAME_HEIGHT, 8);
      while (frame_open()) send_flush();
   endtask

   task automatic test_random_frames();
      int w, h, rx, ry;
      while (pixels_in < RANDOM_PIX) begin
         if (pixels_in > RANDOM_PIX * 3 / 4) idling = 1'b0;
         w  = $urandom_range(1, 10);
         h  = $urandom_range(1, 6);
         rx = $urandom_range(0, 3);
         ry = $urandom_range(0, 3);
         if ($urandom_range(0, 9) == 0) begin
            w  = $urandom_range(0, 1) ? 0 : $urandom_range(11, 16);
            h  = $urandom_range(0, 2);
         end
         if ($urandom_range(0, 9) == 0) begin
            rx = $urandom_range(4, 7);
            ry = $urandom_range(4, 7);
         end
         set_geometry(w, h, rx, ry);
         run_frame(PAT_RANDOM, $urandom_range(0, 2) != 0);
      end
   endtask

   initial begin
      ring_wr    = 0;
      col_in     = 0;
      row_in     = 0;
      out_pos    = 0;
      cfg_width  = 11'd1024;
      cfg_height = 16'd1024;
      cfg_rx     = 3'd1;
      cfg_ry     = 3'd1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_channel_extremes();
      test_degenerate_size();
      test_max_window();
      test_wide_row();
      test_height_change();
      pixels_in = 0;
      test_random_frames();

      wait_idle(RESULT_LAT);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #200_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
